>>> design/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg
// Shared types and constants for the fixed-point biquad section: channel
// payloads, register indexes and the controller-to-datapath command set.
// ----------------------------------------------------------------------------
package bqd_pkg;

  // Sample and accumulator widths fixed by the Q15 / Q31 number formats
  localparam int SampleW = 16;
  localparam int AccW    = 32;
  localparam int RegIdxW = 3;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  // Only -1.0 * -1.0 overflows: raw product equals 2^30
  localparam logic signed [AccW-1:0] MulOvf = {2'b01, {(AccW-2){1'b0}}};
  localparam logic signed [AccW-1:0] RoundK = {{(AccW-SampleW){1'b0}}, 1'b1,
                                               {(SampleW-1){1'b0}}};
  localparam logic signed [SampleW-1:0] SmpMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SmpMin = {1'b1, {(SampleW-1){1'b0}}};

  // Configuration register indexes
  localparam logic [RegIdxW-1:0] REG_B0 = 3'd0;
  localparam logic [RegIdxW-1:0] REG_B1 = 3'd1;
  localparam logic [RegIdxW-1:0] REG_B2 = 3'd2;
  localparam logic [RegIdxW-1:0] REG_A1 = 3'd3;
  localparam logic [RegIdxW-1:0] REG_A2 = 3'd4;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic [RegIdxW-1:0]        reg_index;
    logic signed [SampleW-1:0] wdata;
  } cfg_req_t;

  // Datapath operation for the current cycle
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_MB0  = 3'd1,
    OP_AD1  = 3'd2,
    OP_RND  = 3'd3,
    OP_MA1  = 3'd4,
    OP_AA1  = 3'd5,
    OP_UD1  = 3'd6,
    OP_FIN  = 3'd7
  } op_t;

  typedef struct packed {
    logic load_in;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

>>> design/bqd_chan_if.sv
// ----------------------------------------------------------------------------
// bqd_chan_if
// Valid/ready channel carrying one payload type per request.
// ----------------------------------------------------------------------------
interface bqd_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/bqd_ctrl.sv
// ----------------------------------------------------------------------------
// bqd_ctrl
// Sequencer for one biquad step: walks the shared multiplier and adder
// through the seven operations and holds the last one until the result
// register is free.
// ----------------------------------------------------------------------------
module bqd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output bqd_pkg::dp_cmd_t    cmd,
  input  bqd_pkg::dp_status_t status
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MB0  = 8'b0000_0010,
    ST_AD1  = 8'b0000_0100,
    ST_RND  = 8'b0000_1000,
    ST_MA1  = 8'b0001_0000,
    ST_AA1  = 8'b0010_0000,
    ST_UD1  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance one operation per cycle; hold the final one while output is full
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MB0;
      end
      ST_MB0:  state_next = ST_AD1;
      ST_AD1:  state_next = ST_RND;
      ST_RND:  state_next = ST_MA1;
      ST_MA1:  state_next = ST_AA1;
      ST_AA1:  state_next = ST_UD1;
      ST_UD1:  state_next = ST_FIN;
      ST_FIN: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode the state into a datapath command
  always_comb begin
    cmd.load_in = (state == ST_IDLE) && in_valid;
    case (state)
      ST_MB0:  cmd.op = bqd_pkg::OP_MB0;
      ST_AD1:  cmd.op = bqd_pkg::OP_AD1;
      ST_RND:  cmd.op = bqd_pkg::OP_RND;
      ST_MA1:  cmd.op = bqd_pkg::OP_MA1;
      ST_AA1:  cmd.op = bqd_pkg::OP_AA1;
      ST_UD1:  cmd.op = bqd_pkg::OP_UD1;
      ST_FIN:  cmd.op = bqd_pkg::OP_FIN;
      default: cmd.op = bqd_pkg::OP_NONE;
    endcase
  end

  assign in_ready = (state == ST_IDLE);

endmodule

>>> design/bqd_dp.sv
// ----------------------------------------------------------------------------
// bqd_dp
// Biquad datapath: coefficient registers, delay words, one shared 16x16
// fractional multiplier, one shared saturating 32-bit adder, the rounding
// and negation logic, and the result register.
// ----------------------------------------------------------------------------
module bqd_dp (
  input  logic                clk,
  input  logic                rst,
  input  bqd_pkg::dp_cmd_t    cmd,
  output bqd_pkg::dp_status_t status,
  input  bqd_pkg::in_item_t   in_item,
  input  logic                cfg_valid,
  input  bqd_pkg::cfg_req_t   cfg_req,
  output logic                out_valid,
  output bqd_pkg::out_item_t  out_item,
  input  logic                out_ready
);

  localparam int SW = bqd_pkg::SampleW;
  localparam int AW = bqd_pkg::AccW;

  logic signed [SW-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [SW-1:0] x;
  logic signed [SW-1:0] y;
  logic signed [SW-1:0] yn;
  logic signed [AW-1:0] prod, fwd, fwd2, acc;
  logic signed [AW-1:0] delay_first, delay_second;
  logic                 sat;

  logic signed [SW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] mul_raw, mul_res;
  logic                 mul_sat;
  logic signed [AW-1:0] add_a, add_b, add_res;
  logic signed [AW:0]   add_sum;
  logic                 add_sat;
  logic signed [SW-1:0] rnd_hi, neg_res;
  logic                 neg_sat;
  logic                 sat_next;
  logic                 out_free;

  // Write coefficient registers; indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_valid) begin
      case (cfg_req.reg_index)
        bqd_pkg::REG_B0: coef_b0 <= cfg_req.wdata;
        bqd_pkg::REG_B1: coef_b1 <= cfg_req.wdata;
        bqd_pkg::REG_B2: coef_b2 <= cfg_req.wdata;
        bqd_pkg::REG_A1: coef_a1 <= cfg_req.wdata;
        bqd_pkg::REG_A2: coef_a2 <= cfg_req.wdata;
        default: ;
      endcase
    end
  end

  // Select multiplier operands
  always_comb begin
    case (cmd.op)
      bqd_pkg::OP_AD1: begin mul_a = coef_b1; mul_b = x;       end
      bqd_pkg::OP_RND: begin mul_a = coef_b2; mul_b = x;       end
      bqd_pkg::OP_MA1: begin mul_a = yn;      mul_b = coef_a1; end
      bqd_pkg::OP_AA1: begin mul_a = yn;      mul_b = coef_a2; end
      default:         begin mul_a = coef_b0; mul_b = x;       end
    endcase
  end

  // Fractional multiply: double the product, clamp the single overflow case
  assign mul_raw = AW'(mul_a) * AW'(mul_b);
  assign mul_sat = (mul_raw == bqd_pkg::MulOvf);
  assign mul_res = mul_sat ? bqd_pkg::AccMax : {mul_raw[AW-2:0], 1'b0};

  // Select adder operands
  always_comb begin
    case (cmd.op)
      bqd_pkg::OP_AD1: begin add_a = delay_first;  add_b = prod;           end
      bqd_pkg::OP_RND: begin add_a = acc;          add_b = bqd_pkg::RoundK; end
      bqd_pkg::OP_AA1: begin add_a = prod;         add_b = fwd;            end
      bqd_pkg::OP_UD1: begin add_a = delay_second; add_b = acc;            end
      default:         begin add_a = prod;         add_b = fwd2;           end
    endcase
  end

  // Saturating add: overflow when the two top sum bits disagree
  assign add_sum = {add_a[AW-1], add_a} + {add_b[AW-1], add_b};
  assign add_sat = (add_sum[AW] != add_sum[AW-1]);
  assign add_res = add_sat ? (add_sum[AW] ? bqd_pkg::AccMin : bqd_pkg::AccMax)
                           : add_sum[AW-1:0];

  // Rounded output and its saturating negation
  assign rnd_hi  = add_res[AW-1:AW-SW];
  assign neg_sat = (rnd_hi == bqd_pkg::SmpMin);
  assign neg_res = neg_sat ? bqd_pkg::SmpMax : -rnd_hi;

  // Gather saturation events for the current operation
  always_comb begin
    case (cmd.op)
      bqd_pkg::OP_MB0: sat_next = mul_sat;
      bqd_pkg::OP_AD1: sat_next = sat | add_sat | mul_sat;
      bqd_pkg::OP_RND: sat_next = sat | add_sat | neg_sat | mul_sat;
      bqd_pkg::OP_MA1: sat_next = sat | mul_sat;
      bqd_pkg::OP_AA1: sat_next = sat | add_sat | mul_sat;
      bqd_pkg::OP_UD1: sat_next = sat | add_sat;
      bqd_pkg::OP_FIN: sat_next = sat | add_sat;
      default:         sat_next = sat;
    endcase
  end

  assign out_free        = !out_valid || out_ready;
  assign status.out_free = out_free;

  // Working registers of the step
  always_ff @(posedge clk) begin
    if (cmd.load_in) x <= in_item.sample_in;
    if (cmd.op != bqd_pkg::OP_FIN) sat <= sat_next;
    case (cmd.op)
      bqd_pkg::OP_MB0: prod <= mul_res;
      bqd_pkg::OP_AD1: begin
        acc  <= add_res;
        prod <= mul_res;
      end
      bqd_pkg::OP_RND: begin
        y    <= rnd_hi;
        yn   <= neg_res;
        fwd  <= prod;
        prod <= mul_res;
      end
      bqd_pkg::OP_MA1: begin
        fwd2 <= prod;
        prod <= mul_res;
      end
      bqd_pkg::OP_AA1: begin
        acc  <= add_res;
        prod <= mul_res;
      end
      default: ;
    endcase
  end

  // Update the delay words: first word in its own cycle, second with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_first  <= '0;
      delay_second <= '0;
    end else begin
      if (cmd.op == bqd_pkg::OP_UD1) delay_first <= add_res;
      if (cmd.op == bqd_pkg::OP_FIN && out_free) delay_second <= add_res;
    end
  end

  // Result register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == bqd_pkg::OP_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bqd_pkg::OP_FIN && out_free) begin
      out_item.sample_out <= y;
      out_item.saturated  <= sat_next;
    end
  end

endmodule

>>> design/fixed_point_biquad_iir.sv
// Second-order IIR section, transposed direct form II, Q15 samples and
// coefficients with saturating Q31 arithmetic. A new sample is accepted only
// in the idle state, and the result is registered out of the final operation
// of its step: the five products share one 16x16 multiplier and the four sums
// plus the rounding share one saturating adder, and the recursion through
// the two delay words orders them. The result sits in an output register, so
// a new sample is taken while the previous result waits; only the last cycle
// of a step stalls if that register is still full.
// Coefficient writes are taken every cycle and are meant for idle periods.
// ----------------------------------------------------------------------------
// fixed_point_biquad_iir
// Top level: joins the sequencer and the datapath to the three channels.
// ----------------------------------------------------------------------------
module fixed_point_biquad_iir (
  input  logic       clk,
  input  logic       rst,
  bqd_chan_if.sink   in_ch,
  bqd_chan_if.source out_ch,
  bqd_chan_if.sink   cfg_ch
);

  bqd_pkg::dp_cmd_t    cmd;
  bqd_pkg::dp_status_t status;

  bqd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  bqd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_ch.data),
    .cfg_valid (cfg_ch.valid),
    .cfg_req   (cfg_ch.data),
    .out_valid (out_ch.valid),
    .out_item  (out_ch.data),
    .out_ready (out_ch.ready)
  );

  // Register writes never stall
  assign cfg_ch.ready = 1'b1;

`ifndef SYNTH
  // An accepted sample starts with the first product
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (cmd.op == bqd_pkg::OP_MB0))
    else $error("accepted sample did not start the sequence");

  // A result appears only out of the final operation
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.op == bqd_pkg::OP_FIN))
    else $error("result raised outside the final operation");

  // The final operation with a free slot always delivers
  a_deliver: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == bqd_pkg::OP_FIN && status.out_free) |=> out_ch.valid)
    else $error("finished step produced no result");
`endif

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the biquad section against a bit-exact Q15/Q31 filter computed
// alongside it. Directed samples hit the saturating corners first. Random
// samples then run under several coefficient sets, with random gaps on the
// input side and random stalls on the output side in every phase but one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SampleW     = bqd_pkg::SampleW;
  localparam int AccW        = bqd_pkg::AccW;
  localparam int RegIdxW     = bqd_pkg::RegIdxW;
  localparam int DrainCycles = 24;
  localparam int CycleLimit  = 400000;
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 118;
  localparam int IdxSpan     = 1 << RegIdxW;

  logic clk = 1'b0;
  logic rst;

  bqd_chan_if #(.payload_t(bqd_pkg::in_item_t))  in_ch  ();
  bqd_chan_if #(.payload_t(bqd_pkg::out_item_t)) out_ch ();
  bqd_chan_if #(.payload_t(bqd_pkg::cfg_req_t))  cfg_ch ();

  fixed_point_biquad_iir uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Filter state kept alongside the block
  logic signed [SampleW-1:0] coef_q15 [0:4] = '{default: '0};
  logic signed [AccW-1:0]    state_d1 = '0;
  logic signed [AccW-1:0]    state_d2 = '0;
  bit                        clip_hit;

  bqd_pkg::in_item_t  samples_to_send [$];
  bqd_pkg::out_item_t filtered_due [$];
  int        queued_cnt   = 0;
  int        accepted_cnt = 0;
  int        error_cnt    = 0;
  int        cycle_cnt    = 0;
  bit        jitter_on    = 1'b0;
  bit        in_taken     = 1'b0;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Saturating Q31 helpers
  function automatic logic signed [AccW-1:0] clamp_q31(input longint v);
    if (v > longint'(bqd_pkg::AccMax)) begin
      clip_hit = 1'b1;
      return bqd_pkg::AccMax;
    end
    if (v < longint'(bqd_pkg::AccMin)) begin
      clip_hit = 1'b1;
      return bqd_pkg::AccMin;
    end
    return v[AccW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] q15_mul(input logic signed [SampleW-1:0] a,
                                                      input logic signed [SampleW-1:0] b);
    return clamp_q31(longint'(a) * longint'(b) * 2);
  endfunction

  function automatic logic signed [AccW-1:0] q31_add(input logic signed [AccW-1:0] a,
                                                      input logic signed [AccW-1:0] b);
    return clamp_q31(longint'(a) + longint'(b));
  endfunction

  // One filter step: output sample and clip flag, delay words advanced
  function automatic bqd_pkg::out_item_t filter_sample(input logic signed [SampleW-1:0] x);
    logic signed [AccW-1:0]    acc;
    logic signed [SampleW-1:0] y;
    logic signed [SampleW-1:0] yn;
    bqd_pkg::out_item_t        res;
    clip_hit = 1'b0;
    acc = q31_add(state_d1, q15_mul(coef_q15[bqd_pkg::REG_B0], x));
    // round to Q15: add half an LSB, keep the high half
    acc = q31_add(acc, bqd_pkg::RoundK);
    y = acc[AccW-1:AccW-SampleW];
    if (y == bqd_pkg::SmpMin) begin
      clip_hit = 1'b1;
      yn = bqd_pkg::SmpMax;
    end else begin
      yn = -y;
    end
    acc = q31_add(q15_mul(yn, coef_q15[bqd_pkg::REG_A1]),
                  q15_mul(coef_q15[bqd_pkg::REG_B1], x));
    state_d1 = q31_add(state_d2, acc);
    state_d2 = q31_add(q15_mul(yn, coef_q15[bqd_pkg::REG_A2]),
                       q15_mul(coef_q15[bqd_pkg::REG_B2], x));
    res.sample_out = y;
    res.saturated  = clip_hit;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0d] mismatch: %s", cycle_cnt, what);
    error_cnt++;
  endtask

  // Input driver: advance to the next request once the current one is taken
  always @(posedge clk) begin
    in_taken <= !rst && in_ch.valid && in_ch.ready;
    if (!rst && in_ch.valid && in_ch.ready) begin
      filtered_due.push_back(filter_sample(in_ch.data.sample_in));
      accepted_cnt++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (samples_to_send.size() > 0 && !(jitter_on && $urandom_range(99) < 7)) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= samples_to_send.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output side: stall at random, hold ready otherwise
  always @(negedge clk) begin
    out_ch.ready <= !rst && !(jitter_on && $urandom_range(99) < 7);
  end

  // Monitor: compare each result against the oldest prediction
  always @(posedge clk) begin
    bqd_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (filtered_due.size() == 0) begin
        report_mismatch($sformatf("unexpected output %0d", out_ch.data.sample_out));
      end else begin
        want = filtered_due.pop_front();
        if (out_ch.data.sample_out !== want.sample_out)
          report_mismatch($sformatf("sample_out %0d, want %0d",
                                    out_ch.data.sample_out, want.sample_out));
        if (out_ch.data.saturated !== want.saturated)
          report_mismatch($sformatf("saturated %0b, want %0b (sample %0d)",
                                    out_ch.data.saturated, want.saturated,
                                    want.sample_out));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("fixed_point_biquad_iir test failed");
      $finish;
    end
  end

  task automatic push_sample(input logic signed [SampleW-1:0] x);
    bqd_pkg::in_item_t item;
    item.sample_in = x;
    samples_to_send.push_back(item);
    queued_cnt++;
  endtask

  // Hold until every sample is taken and every output has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_cnt != queued_cnt || filtered_due.size() != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic signed [SampleW-1:0] val);
    bqd_pkg::cfg_req_t req;
    req.reg_index = idx;
    req.wdata     = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= req;
    do @(posedge clk);
    while (!cfg_ch.ready);
    if (idx <= bqd_pkg::REG_A2)
      coef_q15[idx] = val;
  endtask

  task automatic load_coefs(input logic signed [SampleW-1:0] b0, input logic signed [SampleW-1:0] b1,
                            input logic signed [SampleW-1:0] b2, input logic signed [SampleW-1:0] a1,
                            input logic signed [SampleW-1:0] a2, input bit spare_too);
    write_reg(bqd_pkg::REG_B0, b0);
    write_reg(bqd_pkg::REG_B1, b1);
    write_reg(bqd_pkg::REG_B2, b2);
    write_reg(bqd_pkg::REG_A1, a1);
    write_reg(bqd_pkg::REG_A2, a2);
    // indexes past the last register must be dropped by the block
    if (spare_too)
      for (int k = int'(bqd_pkg::REG_A2) + 1; k < IdxSpan; k++)
        write_reg(k[RegIdxW-1:0], SampleW'($urandom));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case (r[31:28])
      4'd0:       return bqd_pkg::SmpMax;
      4'd1:       return bqd_pkg::SmpMin;
      4'd2, 4'd3: return {{(SampleW-9){r[8]}}, r[8:0]};
      default:    return r[SampleW-1:0];
    endcase
  endfunction

  // mode 0: full range, mode 1: corner values, mode 2: small stable filter
  function automatic logic signed [SampleW-1:0] pick_coef(input int mode, input int span);
    logic [31:0] r;
    r = $urandom;
    case (mode)
      0: return r[SampleW-1:0];
      1: begin
        case (r[1:0])
          2'd0:    return bqd_pkg::SmpMax;
          2'd1:    return bqd_pkg::SmpMin;
          2'd2:    return '0;
          default: return '1;
        endcase
      end
      default: return SampleW'($urandom_range(2 * span) - span);
    endcase
  endfunction

  initial begin
    int mode;
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset coefficients: output must stay at zero
    push_sample('0);
    push_sample(bqd_pkg::SmpMax);
    push_sample(bqd_pkg::SmpMin);
    wait_idle();

    // Corner coefficients, minus one squared, spare indexes ignored
    load_coefs(bqd_pkg::SmpMin, bqd_pkg::SmpMin, bqd_pkg::SmpMax, bqd_pkg::SmpMax,
               bqd_pkg::SmpMin, 1'b1);
    push_sample(bqd_pkg::SmpMin);
    push_sample(bqd_pkg::SmpMin);
    push_sample(bqd_pkg::SmpMax);
    push_sample(bqd_pkg::SmpMax);
    push_sample('0);
    push_sample('1);
    push_sample(16'sd1);
    push_sample(bqd_pkg::SmpMin);
    wait_idle();

    // Drive the accumulator to its floor so the output negation clips
    load_coefs(bqd_pkg::SmpMax, bqd_pkg::SmpMin, '0, '0, '0, 1'b0);
    push_sample(bqd_pkg::SmpMax);
    push_sample(bqd_pkg::SmpMin);
    push_sample(bqd_pkg::SmpMax);
    push_sample(bqd_pkg::SmpMin);
    wait_idle();

    // Push the accumulator to its ceiling so rounding overflows
    load_coefs(bqd_pkg::SmpMax, bqd_pkg::SmpMax, bqd_pkg::SmpMax, '0, '0, 1'b0);
    push_sample(bqd_pkg::SmpMax);
    push_sample(bqd_pkg::SmpMax);
    push_sample(bqd_pkg::SmpMax);
    push_sample(bqd_pkg::SmpMin);
    wait_idle();

    // Random phases over several coefficient sets
    for (int p = 0; p < RandPhases; p++) begin
      mode = p % 3;
      jitter_on = (p != 4);
      load_coefs(pick_coef(mode, 8192), pick_coef(mode, 8192), pick_coef(mode, 8192),
                 pick_coef(mode, 16384), pick_coef(mode, 8192), p % 2 == 1);
      for (int i = 0; i < PhaseItems; i++)
        push_sample(pick_sample());
      wait_idle();
    end

    if (error_cnt == 0) begin
      $display("fixed_point_biquad_iir test passed");
    end else begin
      $display("fixed_point_biquad_iir test failed");
    end
    $finish;
  end

endmodule
